// File: design/fpol_pkg.sv
// Shared types, constants and saturating Q16.16 arithmetic for the polarization update block.
`timescale 1ns / 1ps

package fpol_pkg;

  localparam int NODES        = 4096;
  localparam int ADDR_W       = $clog2(NODES);
  localparam int NEWTON_ITERS = 20;
  localparam int ITER_W       = $clog2(NEWTON_ITERS);
  localparam int ROW_W        = 96;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] THREE_Q = 32'sh0003_0000;

  typedef enum logic [2:0] {
    REG_ALPHA     = 3'd0,
    REG_BETA      = 3'd1,
    REG_WELL      = 3'd2,
    REG_GAIN      = 3'd3,
    REG_INV_DX    = 3'd4,
    REG_INV_DY    = 3'd5,
    REG_INV_DZ    = 3'd6,
    REG_ENABLES   = 3'd7
  } reg_idx_t;

  // How the back end treats a node.
  typedef enum logic [1:0] {
    K_SKIP  = 2'd0,
    K_CLEAR = 2'd1,
    K_RUN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic               mode;
    logic [11:0]        node_index;
    logic signed [31:0] phi_center;
    logic signed [31:0] phi_x_minus;
    logic signed [31:0] phi_x_plus;
    logic signed [31:0] phi_y_minus;
    logic signed [31:0] phi_y_plus;
    logic signed [31:0] phi_z_minus;
    logic signed [31:0] phi_z_plus;
    logic [5:0]         neighbour_present;
    logic               in_ferro_region;
  } in_t;

  typedef struct packed {
    logic [11:0]        node_out;
    logic signed [31:0] pol_x;
    logic signed [31:0] pol_y;
    logic signed [31:0] pol_z;
    logic               updated;
  } out_t;

  typedef struct packed {
    logic signed [31:0] coef_alpha;
    logic signed [31:0] coef_beta;
    logic [30:0]        well_level;
    logic [30:0]        step_gain;
    logic [30:0]        inv_dx;
    logic [30:0]        inv_dy;
    logic [30:0]        inv_dz;
    logic [1:0]         enables;
  } cfg_t;

  // One classified node handed from the front end to the back end.
  typedef struct packed {
    kind_t             kind;
    logic              mode;
    logic [11:0]       node;
    logic [2:0][31:0]  e;
  } cmd_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) r = s[32] ? Q_MIN : Q_MAX;
    else r = s[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    return sat33(s);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    return sat33(s);
  endfunction

  // Applies a sign to a magnitude and saturates to 32 bits.
  function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      if (m >= 48'h0000_8000_0000) r = Q_MIN;
      else r = -$signed(m[31:0]);
    end else begin
      if (m > 48'h0000_7FFF_FFFF) r = Q_MAX;
      else r = $signed(m[31:0]);
    end
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] a);
    logic [31:0] r;
    r = a[31] ? 32'(-a) : 32'(a);
    return r;
  endfunction

  // Sign-magnitude product, magnitude truncated, then saturated.
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [63:0] p;
    p = {32'd0, mag32(a)} * {32'd0, mag32(b)};
    return sat_mag(p[63:16], a[31] ^ b[31]);
  endfunction

endpackage

// File: design/fpol_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module fpol_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  fpol_pkg::cmd_t   push_data,
  input  logic             pop,
  output fpol_pkg::cmd_t   head,
  output logic             full,
  output logic             empty
);

  fpol_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign head  = entry_r[rd_ptr_r];
  assign full  = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);

endmodule

// File: design/fpol_div.sv
// Restoring divider, one quotient bit per cycle, for the Newton step.
`timescale 1ns / 1ps

module fpol_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quot
);

  localparam int DVD_W = 48;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [31:0]      den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [32:0]      trial;
  logic [32:0]      diff;

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      cnt_nxt = CNT_W'(DVD_W);
      dvd_nxt = {fpol_pkg::mag32(num), 16'd0};
      rem_nxt = 32'd0;
      den_nxt = fpol_pkg::mag32(den);
      neg_nxt = num[31] ^ den[31];
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy = (cnt_r != '0);
  assign done = done_r;
  assign quot = fpol_pkg::sat_mag(dvd_r, neg_r);

endmodule

// File: design/fpol_front.sv
// Front end: takes nodes, classifies them and forms the three field components.
`timescale 1ns / 1ps

module fpol_front (
  input  logic              clk,
  input  logic              rst_n,
  input  fpol_pkg::cfg_t    cfg,
  input  logic              clr_busy,
  input  logic              in_valid,
  output logic              in_stall,
  input  fpol_pkg::in_t     in_data,
  output logic              q_push,
  output fpol_pkg::cmd_t    q_data,
  input  logic              q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_DIFF = 4'b0010,
    F_MUL  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t            state_r, state_nxt;
  fpol_pkg::in_t      in_r, in_nxt;
  fpol_pkg::kind_t    kind_r, kind_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic signed [32:0] diff_r, diff_nxt;
  logic               half_r, half_nxt;
  logic               none_r, none_nxt;
  logic [2:0][31:0]   e_r, e_nxt;

  logic               accept;
  logic               active;
  logic signed [31:0] lo, hi;
  logic               has_lo, has_hi;
  logic [30:0]        inv;
  logic [32:0]        dmag;
  logic [63:0]        prod;
  logic [47:0]        scaled;
  logic               fneg;

  assign in_stall = (state_r != F_IDLE) || clr_busy;
  assign accept   = in_valid && !in_stall;
  assign active   = cfg.enables[0] && (in_data.mode || cfg.enables[1]);

  always_comb begin
    case (axis_r)
      2'd0: begin
        lo = in_r.phi_x_minus; hi = in_r.phi_x_plus;
        has_lo = in_r.neighbour_present[0]; has_hi = in_r.neighbour_present[1];
        inv = cfg.inv_dx;
      end
      2'd1: begin
        lo = in_r.phi_y_minus; hi = in_r.phi_y_plus;
        has_lo = in_r.neighbour_present[2]; has_hi = in_r.neighbour_present[3];
        inv = cfg.inv_dy;
      end
      2'd2: begin
        lo = in_r.phi_z_minus; hi = in_r.phi_z_plus;
        has_lo = in_r.neighbour_present[4]; has_hi = in_r.neighbour_present[5];
        inv = cfg.inv_dz;
      end
      default: begin
        lo = '0; hi = '0; has_lo = 1'b0; has_hi = 1'b0; inv = '0;
      end
    endcase
  end

  // Field magnitude is |d phi| * inv, halved for a central difference; the
  // sign is opposite to the potential difference.
  always_comb begin
    dmag   = diff_r[32] ? 33'(-diff_r) : 33'(diff_r);
    prod   = {31'd0, dmag} * {33'd0, inv};
    scaled = half_r ? {1'b0, prod[63:17]} : prod[63:16];
    fneg   = !diff_r[32] && (diff_r != '0);
  end

  always_comb begin
    state_nxt = state_r;
    in_nxt    = in_r;
    kind_nxt  = kind_r;
    axis_nxt  = axis_r;
    diff_nxt  = diff_r;
    half_nxt  = half_r;
    none_nxt  = none_r;
    e_nxt     = e_r;
    q_push    = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          in_nxt   = in_data;
          axis_nxt = 2'd0;
          e_nxt    = '0;
          if (!active) begin
            kind_nxt  = fpol_pkg::K_SKIP;
            state_nxt = F_PUSH;
          end else if (!in_data.in_ferro_region) begin
            kind_nxt  = fpol_pkg::K_CLEAR;
            state_nxt = F_PUSH;
          end else begin
            kind_nxt  = fpol_pkg::K_RUN;
            state_nxt = F_DIFF;
          end
        end
      end
      F_DIFF: begin
        half_nxt = has_lo && has_hi;
        none_nxt = !has_lo && !has_hi;
        if (has_lo && has_hi) diff_nxt = {hi[31], hi} - {lo[31], lo};
        else if (has_hi) diff_nxt = {hi[31], hi} - {in_r.phi_center[31], in_r.phi_center};
        else if (has_lo) diff_nxt = {in_r.phi_center[31], in_r.phi_center} - {lo[31], lo};
        else diff_nxt = '0;
        state_nxt = F_MUL;
      end
      F_MUL: begin
        e_nxt[axis_r] = none_r ? 32'd0 : fpol_pkg::sat_mag(scaled, fneg);
        if (axis_r == 2'd2) begin
          state_nxt = F_PUSH;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = F_DIFF;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push    = 1'b1;
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    q_data.kind = kind_r;
    q_data.mode = in_r.mode;
    q_data.node = in_r.node_index;
    q_data.e    = e_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    kind_r <= kind_nxt;
    axis_r <= axis_nxt;
    diff_r <= diff_nxt;
    half_r <= half_nxt;
    none_r <= none_nxt;
    e_r    <= e_nxt;
  end

`ifndef ASSERT_OFF
  a_diff_only_run: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_DIFF) |-> (kind_r == fpol_pkg::K_RUN))
    else $error("field computed for a node that needs none");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into a full command queue");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != F_IDLE))
    else $error("accepted transaction was not taken up");
`endif

endmodule

// File: design/fpol_back.sv
// Back end: polarization store, seeding, Euler and Newton update sequencer, result register.
`timescale 1ns / 1ps

module fpol_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fpol_pkg::cfg_t    cfg,
  output logic              clr_busy,
  input  fpol_pkg::cmd_t    q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output fpol_pkg::out_t    out_data
);

  typedef enum logic [7:0] {
    B_CLEAR = 8'b0000_0001,
    B_IDLE  = 8'b0000_0010,
    B_LOAD  = 8'b0000_0100,
    B_SEED  = 8'b0000_1000,
    B_MUL   = 8'b0001_0000,
    B_DIV   = 8'b0010_0000,
    B_WRITE = 8'b0100_0000,
    B_OUT   = 8'b1000_0000
  } bstate_t;

  localparam logic [fpol_pkg::ADDR_W-1:0] LAST_ROW = fpol_pkg::ADDR_W'(fpol_pkg::NODES - 1);
  localparam logic [fpol_pkg::ITER_W-1:0] LAST_ITER =
    fpol_pkg::ITER_W'(fpol_pkg::NEWTON_ITERS - 1);

  logic [fpol_pkg::ROW_W-1:0] mem [fpol_pkg::NODES];
  logic [fpol_pkg::ROW_W-1:0] rdata_r;

  bstate_t                     state_r, state_nxt;
  logic [fpol_pkg::ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  fpol_pkg::cmd_t              cmd_r, cmd_nxt;
  logic signed [31:0]          p_r [3];
  logic signed [31:0]          p_nxt [3];
  logic [1:0]                  comp_r, comp_nxt;
  logic [2:0]                  step_r, step_nxt;
  logic [fpol_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic signed [31:0]          t1_r, t1_nxt;
  logic signed [31:0]          cub_r, cub_nxt;
  logic signed [31:0]          f_r, f_nxt;
  logic signed [31:0]          tb_r, tb_nxt;
  logic signed [31:0]          prod_r;

  logic                        we, re;
  logic [fpol_pkg::ADDR_W-1:0] waddr, raddr;
  logic [fpol_pkg::ROW_W-1:0]  wdata;
  logic signed [31:0]          mop_a, mop_b;
  logic signed [31:0]          pc, ec, df;
  logic                        comp_done;
  logic                        div_start, div_busy, div_done;
  logic signed [31:0]          div_quot;

  fpol_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (f_r),
    .den   (df),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign pc = p_r[comp_r];
  assign ec = $signed(cmd_r.e[comp_r]);
  assign df = fpol_pkg::qadd(cfg.coef_alpha, prod_r);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd_nxt      = cmd_r;
    p_nxt        = p_r;
    comp_nxt     = comp_r;
    step_nxt     = step_r;
    iter_nxt     = iter_r;
    t1_nxt       = t1_r;
    cub_nxt      = cub_r;
    f_nxt        = f_r;
    tb_nxt       = tb_r;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = cmd_r.node[fpol_pkg::ADDR_W-1:0];
    raddr        = q_head.node[fpol_pkg::ADDR_W-1:0];
    wdata        = {p_r[2], p_r[1], p_r[0]};
    q_pop        = 1'b0;
    div_start    = 1'b0;
    mop_a        = '0;
    mop_b        = '0;
    comp_done    = 1'b0;
    unique case (state_r)
      B_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_addr_r;
        wdata        = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ROW) state_nxt = B_IDLE;
      end
      B_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          cmd_nxt = q_head;
          if (q_head.kind == fpol_pkg::K_CLEAR) begin
            p_nxt[0]  = '0;
            p_nxt[1]  = '0;
            p_nxt[2]  = '0;
            state_nxt = B_WRITE;
          end else begin
            re        = 1'b1;
            state_nxt = B_LOAD;
          end
        end
      end
      B_LOAD: begin
        p_nxt[0]  = $signed(rdata_r[31:0]);
        p_nxt[1]  = $signed(rdata_r[63:32]);
        p_nxt[2]  = $signed(rdata_r[95:64]);
        tb_nxt    = fpol_pkg::qmul(fpol_pkg::THREE_Q, cfg.coef_beta);
        comp_nxt  = 2'd0;
        state_nxt = (cmd_r.kind == fpol_pkg::K_SKIP) ? B_OUT : B_SEED;
      end
      B_SEED: begin
        if (pc == '0) begin
          if (ec > 0) p_nxt[comp_r] = $signed({1'b0, cfg.well_level});
          else if (ec < 0) p_nxt[comp_r] = -$signed({1'b0, cfg.well_level});
        end
        step_nxt  = 3'd0;
        iter_nxt  = '0;
        state_nxt = B_MUL;
      end
      B_MUL: begin
        step_nxt = step_r + 3'd1;
        case (step_r)
          3'd0: begin mop_a = cfg.coef_alpha; mop_b = pc; end
          3'd1: begin t1_nxt = prod_r; mop_a = cfg.coef_beta; mop_b = pc; end
          3'd2: begin mop_a = prod_r; mop_b = pc; end
          3'd3: begin mop_a = prod_r; mop_b = pc; end
          3'd4: cub_nxt = fpol_pkg::qadd(t1_r, prod_r);
          3'd5: begin
            if (cmd_r.mode) begin
              f_nxt = fpol_pkg::qsub(cub_r, ec);
              mop_a = tb_r;
              mop_b = pc;
            end else begin
              mop_a = $signed({1'b0, cfg.step_gain});
              mop_b = fpol_pkg::qsub(ec, cub_r);
            end
          end
          3'd6: begin
            if (cmd_r.mode) begin
              mop_a = prod_r;
              mop_b = pc;
            end else begin
              p_nxt[comp_r] = fpol_pkg::qadd(pc, prod_r);
              comp_done     = 1'b1;
            end
          end
          default: begin
            if (df == '0) begin
              comp_done = 1'b1;
            end else begin
              div_start = 1'b1;
              state_nxt = B_DIV;
            end
          end
        endcase
      end
      B_DIV: begin
        if (div_done) begin
          p_nxt[comp_r] = fpol_pkg::qsub(pc, div_quot);
          if ((div_quot == '0) || (iter_r == LAST_ITER)) begin
            comp_done = 1'b1;
          end else begin
            iter_nxt  = iter_r + 1'b1;
            step_nxt  = 3'd0;
            state_nxt = B_MUL;
          end
        end
      end
      B_WRITE: begin
        we        = 1'b1;
        state_nxt = B_OUT;
      end
      B_OUT: begin
        if (!out_stall) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
    if (comp_done) begin
      if (comp_r == 2'd2) begin
        state_nxt = B_WRITE;
      end else begin
        comp_nxt  = comp_r + 2'd1;
        state_nxt = B_SEED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= B_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    p_r    <= p_nxt;
    comp_r <= comp_nxt;
    step_r <= step_nxt;
    iter_r <= iter_nxt;
    t1_r   <= t1_nxt;
    cub_r  <= cub_nxt;
    f_r    <= f_nxt;
    tb_r   <= tb_nxt;
    prod_r <= fpol_pkg::qmul(mop_a, mop_b);
  end

  assign clr_busy  = (state_r == B_CLEAR);
  assign out_valid = (state_r == B_OUT);

  always_comb begin
    out_data.node_out = cmd_r.node;
    out_data.pol_x    = p_r[0];
    out_data.pol_y    = p_r[1];
    out_data.pol_z    = p_r[2];
    out_data.updated  = (cmd_r.kind != fpol_pkg::K_SKIP);
  end

`ifndef ASSERT_OFF
  a_div_alive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (div_busy || div_done))
    else $error("waiting on a divider that is not running");
  a_skip_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (we && state_r != B_CLEAR) |-> (cmd_r.kind != fpol_pkg::K_SKIP))
    else $error("store written for a disabled node");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_OUT && out_stall) |=> (state_r == B_OUT) && $stable(out_data))
    else $error("result changed while stalled");
`endif

endmodule

// File: design/ferroelectric_polarization_update.sv
// Top level of the Landau-Khalatnikov polarization update block.
`timescale 1ns / 1ps

// Front end: a skipped or cleared node goes straight to the queue; a field node passes a
// difference and a multiply state per axis. Back end: a Newton node runs up to 20 iterations
// per component, each a multiply sequence and a divide.
// Throughput is set by the shared multiplier sequence and the one-bit-per-cycle divider.
// Reset: synchronous, active low; afterwards a pass over all 4096 rows zeroes the store, with
// no node accepted during it; configuration registers reset to zero.

module ferroelectric_polarization_update (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fpol_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fpol_pkg::out_t  out_data,
  input  logic            cfg_wr_en,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_wdata
);

  // Configuration registers. The user must write them only while the block is idle; the block
  // itself does not enforce this, and both halves read them directly.
  fpol_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (fpol_pkg::reg_idx_t'(cfg_index))
        fpol_pkg::REG_ALPHA:   cfg_nxt.coef_alpha = $signed(cfg_wdata);
        fpol_pkg::REG_BETA:    cfg_nxt.coef_beta  = $signed(cfg_wdata);
        fpol_pkg::REG_WELL:    cfg_nxt.well_level = cfg_wdata[30:0];
        fpol_pkg::REG_GAIN:    cfg_nxt.step_gain  = cfg_wdata[30:0];
        fpol_pkg::REG_INV_DX:  cfg_nxt.inv_dx     = cfg_wdata[30:0];
        fpol_pkg::REG_INV_DY:  cfg_nxt.inv_dy     = cfg_wdata[30:0];
        fpol_pkg::REG_INV_DZ:  cfg_nxt.inv_dz     = cfg_wdata[30:0];
        fpol_pkg::REG_ENABLES: cfg_nxt.enables    = cfg_wdata[1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end classifies each transaction and computes its field; the queue lets
  // it take the next node while the back end is still iterating.
  logic           clr_busy;
  logic           q_push, q_pop, q_full, q_empty;
  fpol_pkg::cmd_t q_data, q_head;

  fpol_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .clr_busy (clr_busy),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_data),
    .q_full   (q_full)
  );

  fpol_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The back end owns the store, runs one node at a time and holds the result in its
  // output register until the downstream side takes the transaction.
  fpol_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .clr_busy  (clr_busy),
    .q_head    (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_ferroelectric_polarization_update.sv
// Self-checking testbench for the ferroelectric polarization update block.
`timescale 1ns / 1ps

module tb_ferroelectric_polarization_update;
  import fpol_pkg::*;

  localparam int STALL_LIMIT = 30000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_t        in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_t       out_data;
  logic       cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  ferroelectric_polarization_update uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Nodes waiting to be offered, and polarization results predicted for accepted nodes.
  in_t  node_queue[$];
  out_t pol_expected[$];
  int   error_count = 0;
  int   results_seen = 0;

  // Shadow of the configuration registers and of the polarization store.
  longint sh_alpha, sh_beta, sh_well, sh_gain, sh_inv[3];
  logic [1:0] sh_enables;
  int pol_mem[0:3*NODES-1];

  // ---------------------------------------------------------------------------
  // Saturating Q16.16 arithmetic, computed in 64 bits and clamped to 32.
  // ---------------------------------------------------------------------------
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] absval(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Signs a magnitude; the magnitude is first capped at 47 bits.
  function automatic longint signed_mag(logic [63:0] m, bit neg);
    if (m > 64'h7FFF_FFFF_FFFF) m = 64'h7FFF_FFFF_FFFF;
    return clamp32(neg ? -longint'(m) : longint'(m));
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return signed_mag((absval(a) * absval(b)) >> 16, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint d);
    return signed_mag((absval(a) << 16) / absval(d), (a < 0) != (d < 0));
  endfunction

  // Field along one axis is minus the potential slope; central differences are halved.
  function automatic longint axis_field(longint lo, longint c, longint hi,
                                        bit has_lo, bit has_hi, longint inv);
    longint diff;
    int sh;
    sh = 16;
    if (has_lo && has_hi) begin
      diff = hi - lo;
      sh = 17;
    end else if (has_hi) begin
      diff = hi - c;
    end else if (has_lo) begin
      diff = c - lo;
    end else begin
      return 0;
    end
    return signed_mag((absval(diff) * 64'(inv)) >> sh, diff > 0);
  endfunction

  // Landau restoring term alpha*P + beta*P^3.
  function automatic longint landau_force(longint p);
    return clamp32(fx_mul(sh_alpha, p) + fx_mul(fx_mul(fx_mul(sh_beta, p), p), p));
  endfunction

  function automatic longint newton_solve(longint p, longint e);
    longint three_beta, f, df, dp;
    three_beta = fx_mul(longint'(3) <<< 16, sh_beta);
    for (int it = 0; it < NEWTON_ITERS; it++) begin
      f  = clamp32(landau_force(p) - e);
      df = clamp32(sh_alpha + fx_mul(fx_mul(three_beta, p), p));
      if (df == 0) break;
      dp = fx_div(f, df);
      p  = clamp32(p - dp);
      if (dp == 0) break;
    end
    return p;
  endfunction

  // Works out the new polarization of an accepted node and updates the shadow store.
  function automatic void predict_polarization(in_t t);
    out_t r;
    int base;
    bit active;
    longint e[3], p, pc;
    longint lo[3], hi[3];
    base = int'(t.node_index) * 3;
    active = sh_enables[0] && (t.mode || sh_enables[1]);
    pc = t.phi_center;
    lo[0] = t.phi_x_minus; hi[0] = t.phi_x_plus;
    lo[1] = t.phi_y_minus; hi[1] = t.phi_y_plus;
    lo[2] = t.phi_z_minus; hi[2] = t.phi_z_plus;
    if (active) begin
      if (!t.in_ferro_region) begin
        for (int c = 0; c < 3; c++) pol_mem[base + c] = 0;
      end else begin
        for (int c = 0; c < 3; c++) begin
          e[c] = axis_field(lo[c], pc, hi[c], t.neighbour_present[2*c],
                            t.neighbour_present[2*c+1], sh_inv[c]);
          p = pol_mem[base + c];
          // A pristine component is seeded into the well that the field points to.
          if (p == 0) begin
            if (e[c] > 0) p = sh_well;
            else if (e[c] < 0) p = -sh_well;
          end
          if (t.mode) p = newton_solve(p, e[c]);
          else p = clamp32(p + fx_mul(sh_gain, clamp32(e[c] - landau_force(p))));
          pol_mem[base + c] = int'(p);
        end
      end
    end
    r.node_out = t.node_index;
    r.pol_x    = pol_mem[base];
    r.pol_y    = pol_mem[base + 1];
    r.pol_z    = pol_mem[base + 2];
    r.updated  = active;
    pol_expected.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued nodes in bursts with random gaps; a stalled
  // transaction is held unchanged. Prediction happens on acceptance.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (in_valid && !in_stall) predict_polarization(in_data);
    if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (node_queue.size() > 0) begin
        in_data  <= node_queue.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          // Some bursts run long with no gap at all.
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switches between stall densities every so often, and once
  // holds off for a long stretch so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  int stall_pct = 0;
  int pattern_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!hold_done && results_seen >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_left <= $urandom_range(50, 300);
        case ($urandom_range(2))
          0: stall_pct <= 0;
          1: stall_pct <= 30;
          default: stall_pct <= 75;
        endcase
      end else begin
        pattern_left <= pattern_left - 1;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: each accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    out_t w;
    if (rst_n && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (pol_expected.size() == 0) begin
        report_mismatch("unexpected result, node", out_data.node_out, -1);
      end else begin
        w = pol_expected.pop_front();
        if (out_data.node_out !== w.node_out)
          report_mismatch("node_out", out_data.node_out, w.node_out);
        if (out_data.pol_x !== w.pol_x) report_mismatch("pol_x", out_data.pol_x, w.pol_x);
        if (out_data.pol_y !== w.pol_y) report_mismatch("pol_y", out_data.pol_y, w.pol_y);
        if (out_data.pol_z !== w.pol_z) report_mismatch("pol_z", out_data.pol_z, w.pol_z);
        if (out_data.updated !== w.updated)
          report_mismatch("updated", out_data.updated, w.updated);
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired at %0t", $realtime);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      REG_ALPHA:  sh_alpha = longint'($signed(value));
      REG_BETA:   sh_beta = longint'($signed(value));
      REG_WELL:   sh_well = value[30:0];
      REG_GAIN:   sh_gain = value[30:0];
      REG_INV_DX: sh_inv[0] = value[30:0];
      REG_INV_DY: sh_inv[1] = value[30:0];
      REG_INV_DZ: sh_inv[2] = value[30:0];
      default:    sh_enables = value[1:0];
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(logic [31:0] alpha, logic [31:0] beta, logic [31:0] well,
                           logic [31:0] gain, logic [31:0] idx, logic [31:0] idy,
                           logic [31:0] idz, logic [31:0] en);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_BETA, beta);
    write_reg(REG_WELL, well);
    write_reg(REG_GAIN, gain);
    write_reg(REG_INV_DX, idx);
    write_reg(REG_INV_DY, idy);
    write_reg(REG_INV_DZ, idz);
    write_reg(REG_ENABLES, en);
  endtask

  // Waits until every queued node has been accepted and answered, then lets the
  // block settle before the next register write.
  task automatic drain();
    while (node_queue.size() > 0 || in_valid || pol_expected.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic in_t make_node(bit mode, logic [11:0] node, logic [31:0] pc,
                                    logic [31:0] xm, logic [31:0] xp, logic [31:0] ym,
                                    logic [31:0] yp, logic [31:0] zm, logic [31:0] zp,
                                    logic [5:0] nb, bit ferro);
    in_t t;
    t.mode = mode; t.node_index = node; t.phi_center = pc;
    t.phi_x_minus = xm; t.phi_x_plus = xp; t.phi_y_minus = ym; t.phi_y_plus = yp;
    t.phi_z_minus = zm; t.phi_z_plus = zp;
    t.neighbour_present = nb; t.in_ferro_region = ferro;
    return t;
  endfunction

  // Random potential: mostly a smooth neighbourhood, sometimes any 32-bit value.
  function automatic logic [31:0] rand_phi(logic [31:0] centre);
    if ($urandom_range(4) == 0) return $urandom;
    return centre + 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh1_FFFF);
  endfunction

  // Random nodes revisit a small set of addresses so that the store evolves.
  task automatic add_random_nodes(int count, int newton_pct);
    logic [31:0] c;
    logic [11:0] node;
    for (int i = 0; i < count; i++) begin
      c = ($urandom_range(1) == 0) ? $urandom : 32'($signed($urandom_range(0, 32'hF_FFFF))
          - 32'sh8_0000);
      node = ($urandom_range(9) < 8) ? 12'($urandom_range(15)) : 12'($urandom);
      node_queue.push_back(make_node($urandom_range(99) < newton_pct, node, c,
        rand_phi(c), rand_phi(c), rand_phi(c), rand_phi(c), rand_phi(c), rand_phi(c),
        6'($urandom), $urandom_range(9) != 0));
    end
  endtask

  initial begin
    for (int i = 0; i < 3*NODES; i++) pol_mem[i] = 0;
    sh_alpha = 0; sh_beta = 0; sh_well = 0; sh_gain = 0;
    sh_inv[0] = 0; sh_inv[1] = 0; sh_inv[2] = 0; sh_enables = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset everything is disabled, so nodes only read back the store.
    add_random_nodes(10, 20);
    drain();

    // Directed nodes on a well-behaved double well.
    configure(32'hFFFE_0000, 32'h0001_0000, 32'h0001_6A09, 32'h0000_1000,
              32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'd3);
    // Pristine node, field positive on x, negative on y, zero on z.
    node_queue.push_back(make_node(0, 12'd0, 32'h0001_0000, 32'h0002_0000, 32'h0,
      32'h0, 32'h0002_0000, 32'h0, 32'h0, 6'b001111, 1));
    // Same node again, now seeded, with one-sided differences along x, y and z.
    node_queue.push_back(make_node(0, 12'd0, 32'h0001_0000, 32'h0, 32'h0003_0000,
      32'h0, 32'h0, 32'h0002_0000, 32'h0, 6'b010010, 1));
    node_queue.push_back(make_node(0, 12'd0, 32'h0001_0000, 32'h0, 32'h0,
      32'h0, 32'h0, 32'h0, 32'h0002_0000, 6'b100100, 1));
    // Newton solve on the seeded node and on a pristine node at the top address.
    node_queue.push_back(make_node(1, 12'd0, 32'h0, 32'h0001_0000, 32'hFFFF_0000,
      32'h0, 32'h0, 32'h0, 32'h0, 6'b111111, 1));
    node_queue.push_back(make_node(1, 12'd4095, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 6'b111111, 1));
    // Extreme potentials with each one-sided form.
    node_queue.push_back(make_node(0, 12'd4095, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
      6'b010101, 1));
    node_queue.push_back(make_node(0, 12'd4095, 32'h8000_0000, 32'h7FFF_FFFF,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
      6'b101010, 1));
    // No neighbours at all gives zero field.
    node_queue.push_back(make_node(1, 12'd7, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'b000000, 1));
    // Outside the ferroelectric region the node is cleared.
    node_queue.push_back(make_node(0, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 6'b111111, 0));
    node_queue.push_back(make_node(1, 12'd4095, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
      6'b111111, 0));
    // Pristine node in Euler mode right after clearing, then Newton on it.
    node_queue.push_back(make_node(0, 12'd0, 32'h0, 32'h0000_0001, 32'hFFFF_FFFF,
      32'h0, 32'h0, 32'h0, 32'h0, 6'b000011, 1));
    node_queue.push_back(make_node(1, 12'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
      32'h0, 6'b111111, 1));
    add_random_nodes(8, 25);
    drain();

    add_random_nodes(400, 10);
    drain();

    // Only ferroelectric enabled: Euler nodes are skipped, Newton nodes run.
    configure(32'hFFFC_0000, 32'h0002_0000, 32'h0001_0000, 32'h0000_4000,
              32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 32'd1);
    add_random_nodes(100, 30);
    drain();

    // Damping bit alone leaves the block disabled.
    configure(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000,
              32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd2);
    add_random_nodes(50, 20);
    drain();

    // Largest magnitudes everywhere.
    configure(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_random_nodes(200, 5);
    drain();

    configure(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd3);
    add_random_nodes(100, 5);
    drain();

    // Random settings of moderate size.
    configure(32'($signed($urandom_range(0, 32'h8_0000)) - 32'sh4_0000),
              $urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000),
              $urandom_range(0, 32'h8000), $urandom_range(0, 32'h4_0000),
              $urandom_range(0, 32'h4_0000), $urandom_range(0, 32'h4_0000), 32'd3);
    add_random_nodes(330, 8);
    drain();

    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: files.f
design/fpol_pkg.sv
design/fpol_queue.sv
design/fpol_div.sv
design/fpol_front.sv
design/fpol_back.sv
design/ferroelectric_polarization_update.sv
tb/tb_ferroelectric_polarization_update.sv
